>>> design/sgrp_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes of the surface grid record parser
package sgrp_pkg;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 4;
    localparam int POS_W   = 24;
    localparam int ERR_W   = 3;
    localparam int KIND_W  = 2;
    localparam int HCNT_W  = 5;

    // default limit on the number of grid cells
    localparam int MAX_GRID_CELLS_DEF = 16777216;

    // result queue depth, room for two results of one request plus slack
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [WORD_W-1:0] HEADER_ID_RESET = -32'sd996;

    // framing constants of the header records
    localparam logic [WORD_W-1:0] REC1_LEN = 32'd32;
    localparam logic [WORD_W-1:0] REC2_LEN = 32'd16;
    localparam logic [WORD_W-1:0] REC3_LEN = 32'd28;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIELD = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_CHUNK     = 3'd1,
        ERR_TRAILER   = 3'd2,
        ERR_ID        = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_BLOCK     = 3'd5,
        ERR_GRID_SIZE = 3'd6,
        ERR_OVERRUN   = 3'd7
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] field_number;
        logic [POS_W-1:0]   position;
        logic [WORD_W-1:0]  value;
        err_t               error_code;
        logic               end_of_run;
    } result_t;

    // results produced by one request, first one in slot a
    typedef struct packed {
        logic [1:0] count;
        result_t    a;
        result_t    b;
    } push_t;

endpackage

>>> design/sgrp_stream_if.sv
`timescale 1ns / 1ps
// stream interfaces for input words and parser results
interface sgrp_word_if;
    import sgrp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              start_of_file;
    logic              last_word;

    modport source (output valid, word, start_of_file, last_word, input ready);
    modport sink   (input valid, word, start_of_file, last_word, output ready);
endinterface

interface sgrp_result_if;
    import sgrp_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] field_number;
    logic [POS_W-1:0]   position;
    logic [WORD_W-1:0]  value;
    logic [ERR_W-1:0]   error_code;
    logic               end_of_run;

    modport source (output valid, kind, field_number, position, value, error_code,
                     end_of_run, input ready);
    modport sink   (input valid, kind, field_number, position, value, error_code,
                     end_of_run, output ready);
endinterface

>>> design/sgrp_parser.sv
`timescale 1ns / 1ps
// parser state and per-word decode of header, record framing and grid values
module sgrp_parser #(
    parameter int MAX_GRID_CELLS = sgrp_pkg::MAX_GRID_CELLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [sgrp_pkg::WORD_W-1:0]   word,
    input  logic                          start_of_file,
    input  logic                          last_word,
    input  logic                          cfg_we,
    input  logic signed [sgrp_pkg::WORD_W-1:0] cfg_wdata,
    output sgrp_pkg::push_t               push
);
    import sgrp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_GRID_CELLS + 2);
    localparam int PROD_W = 2 * CNT_W;
    localparam int Q_W    = WORD_W - 2;
    localparam int CMP_W  = (PROD_W > Q_W) ? PROD_W + 1 : Q_W + 2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_HEAD    = 3'd1,
        PH_VALUES  = 3'd2,
        PH_TRAILER = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    phase_t                    phase_reg, phase_next, phase_eff;
    logic [HCNT_W-1:0]         hcnt_reg, hcnt_next, hcnt_eff;
    logic [CNT_W-1:0]          rows_reg, rows_next, rows_eff;
    logic [CNT_W-1:0]          cols_reg, cols_next, cols_eff;
    logic [WORD_W-1:0]         rec_len_reg, rec_len_next;
    logic [Q_W-1:0]            left_reg, left_next, left_eff;
    logic [CNT_W-1:0]          cells_reg, cells_next, cells_eff;
    logic [CNT_W-1:0]          col_cnt_reg, col_cnt_next, col_cnt_eff;
    logic [CNT_W-1:0]          row_cnt_reg, row_cnt_next, row_cnt_eff;
    logic [CNT_W-1:0]          col_base_reg, col_base_next, col_base_eff;
    logic [PROD_W-1:0]         total_reg;
    logic signed [WORD_W-1:0]  header_id_reg;

    logic [WORD_W-1:0]         w;
    logic [Q_W-1:0]            q;
    logic [CNT_W-1:0]          sat_w;
    logic [CNT_W-1:0]          col_inc;
    logic                      size_bad;
    result_t                   res [2];
    logic [1:0]                n;

    assign w     = {word[7:0], word[15:8], word[23:16], word[31:24]};
    assign q     = w[WORD_W-1:2];
    assign sat_w = (w > WORD_W'(MAX_GRID_CELLS)) ? CNT_W'(MAX_GRID_CELLS + 1) : CNT_W'(w);

    // a new file clears the parser before its first word is decoded
    always_comb
    begin
        if (start_of_file)
        begin
            phase_eff    = PH_HEADER;
            hcnt_eff     = '0;
            rows_eff     = '0;
            cols_eff     = '0;
            left_eff     = '0;
            cells_eff    = '0;
            col_cnt_eff  = '0;
            row_cnt_eff  = '0;
            col_base_eff = '0;
        end
        else
        begin
            phase_eff    = phase_reg;
            hcnt_eff     = hcnt_reg;
            rows_eff     = rows_reg;
            cols_eff     = cols_reg;
            left_eff     = left_reg;
            cells_eff    = cells_reg;
            col_cnt_eff  = col_cnt_reg;
            row_cnt_eff  = row_cnt_reg;
            col_base_eff = col_base_reg;
        end
    end

    assign size_bad = (rows_reg > CNT_W'(MAX_GRID_CELLS)) || (cols_reg > CNT_W'(MAX_GRID_CELLS)) ||
                      (total_reg > PROD_W'(MAX_GRID_CELLS));
    assign col_inc  = col_cnt_eff + 1'b1;

    always_comb
    begin
        phase_next    = phase_eff;
        hcnt_next     = hcnt_eff;
        rows_next     = rows_eff;
        cols_next     = cols_eff;
        rec_len_next  = rec_len_reg;
        left_next     = left_eff;
        cells_next    = cells_eff;
        col_cnt_next  = col_cnt_eff;
        row_cnt_next  = row_cnt_eff;
        col_base_next = col_base_eff;
        res[0]        = '0;
        res[1]        = '0;
        n             = 2'd0;

        case (phase_eff)
            PH_HEADER:
            begin
                hcnt_next = hcnt_eff + 1'b1;
                if (hcnt_eff == 5'd0)
                begin
                    if (w != REC1_LEN)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_CHUNK;
                    end
                end
                else if (hcnt_eff == 5'd1)
                begin
                    if (w != $unsigned(header_id_reg))
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_ID;
                    end
                end
                else if (hcnt_eff inside {[5'd2:5'd8]})
                begin
                    if (hcnt_eff == 5'd2)
                        rows_next = sat_w;
                    res[0].kind         = KIND_FIELD;
                    res[0].field_number = FIELD_W'(hcnt_eff - 5'd2);
                    res[0].value        = w;
                end
                else if (hcnt_eff == 5'd9)
                begin
                    if (w != REC1_LEN)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_TRAILER;
                    end
                end
                else if (hcnt_eff == 5'd10)
                begin
                    if (w != REC2_LEN)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_CHUNK;
                    end
                end
                else if (hcnt_eff inside {[5'd11:5'd14]})
                begin
                    if (hcnt_eff == 5'd11)
                        cols_next = sat_w;
                    res[0].kind         = KIND_FIELD;
                    res[0].field_number = FIELD_W'(hcnt_eff - 5'd4);
                    res[0].value        = w;
                end
                else if (hcnt_eff == 5'd15)
                begin
                    if (w != REC2_LEN)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_TRAILER;
                    end
                end
                else if (hcnt_eff == 5'd16)
                begin
                    if (w != REC3_LEN)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_CHUNK;
                    end
                end
                else if (hcnt_eff >= 5'd24)
                begin
                    hcnt_next = hcnt_eff;
                    if (w != REC3_LEN)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_TRAILER;
                    end
                    else if (size_bad)
                    begin
                        res[0].kind = KIND_ERROR; res[0].error_code = ERR_GRID_SIZE;
                    end
                    else if (total_reg == '0)
                    begin
                        res[0].kind = KIND_DONE;
                        phase_next  = PH_DONE;
                    end
                    else
                        phase_next = PH_HEAD;
                end
                if (res[0].kind == KIND_ERROR)
                begin
                    phase_next = PH_ERROR;
                    hcnt_next  = hcnt_eff;
                end
                // one result for errors, done and field words; framing words leave kind at its zero default
                if (res[0].kind == KIND_ERROR || res[0].kind == KIND_DONE ||
                    (res[0].kind == KIND_FIELD &&
                     (hcnt_eff inside {[5'd2:5'd8], [5'd11:5'd14]})))
                    n = 2'd1;
            end
            PH_HEAD:
            begin
                if (w[WORD_W-1])
                begin
                    res[0].kind = KIND_ERROR; res[0].error_code = ERR_CHUNK;
                    phase_next  = PH_ERROR;
                    n           = 2'd1;
                end
                else if ((CMP_W'(cells_eff) + CMP_W'(q)) > CMP_W'(total_reg))
                begin
                    res[0].kind = KIND_ERROR; res[0].error_code = ERR_OVERRUN;
                    phase_next  = PH_ERROR;
                    n           = 2'd1;
                end
                else
                begin
                    rec_len_next = w;
                    left_next    = q;
                    phase_next   = (q != '0) ? PH_VALUES : PH_TRAILER;
                end
            end
            PH_VALUES:
            begin
                res[0].kind     = KIND_VALUE;
                res[0].position = POS_W'(row_cnt_eff + col_base_eff);
                res[0].value    = w;
                n               = 2'd1;
                cells_next      = cells_eff + 1'b1;
                if (col_inc >= cols_eff)
                begin
                    col_cnt_next  = '0;
                    col_base_next = '0;
                    row_cnt_next  = row_cnt_eff + 1'b1;
                end
                else
                begin
                    col_cnt_next  = col_inc;
                    col_base_next = col_base_eff + rows_eff;
                end
                left_next = left_eff - 1'b1;
                if (left_eff == Q_W'(1))
                    phase_next = PH_TRAILER;
            end
            PH_TRAILER:
            begin
                if (w != rec_len_reg)
                begin
                    res[0].kind = KIND_ERROR; res[0].error_code = ERR_BLOCK;
                    phase_next  = PH_ERROR;
                    n           = 2'd1;
                end
                else if (CMP_W'(cells_eff) >= CMP_W'(total_reg))
                begin
                    res[0].kind = KIND_DONE;
                    phase_next  = PH_DONE;
                    n           = 2'd1;
                end
                else
                    phase_next = PH_HEAD;
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase

        // buffer ends before the file is complete
        if (last_word && phase_next != PH_DONE && phase_next != PH_ERROR)
        begin
            phase_next = PH_ERROR;
            if (n == 2'd0)
            begin
                res[0].kind = KIND_ERROR; res[0].error_code = ERR_TRUNCATED;
            end
            else
            begin
                res[1].kind = KIND_ERROR; res[1].error_code = ERR_TRUNCATED;
            end
            n = n + 2'd1;
        end

        if (n == 2'd1)
            res[0].end_of_run = 1'b1;
        else if (n == 2'd2)
            res[1].end_of_run = 1'b1;
    end

    assign push.count = accept ? n : 2'd0;
    assign push.a     = res[0];
    assign push.b     = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hcnt_reg      <= '0;
            rows_reg      <= '0;
            cols_reg      <= '0;
            rec_len_reg   <= '0;
            left_reg      <= '0;
            cells_reg     <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            col_base_reg  <= '0;
            total_reg     <= '0;
            header_id_reg <= HEADER_ID_RESET;
        end
        else
        begin
            // product is registered from the size registers, long before the header ends
            total_reg <= PROD_W'(rows_reg) * PROD_W'(cols_reg);
            if (cfg_we)
                header_id_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg    <= phase_next;
                hcnt_reg     <= hcnt_next;
                rows_reg     <= rows_next;
                cols_reg     <= cols_next;
                rec_len_reg  <= rec_len_next;
                left_reg     <= left_next;
                cells_reg    <= cells_next;
                col_cnt_reg  <= col_cnt_next;
                row_cnt_reg  <= row_cnt_next;
                col_base_reg <= col_base_next;
            end
        end
    end

endmodule

>>> design/sgrp_result_queue.sv
`timescale 1ns / 1ps
// small result queue, up to two pushes and one pop per cycle
module sgrp_result_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  sgrp_pkg::push_t push,
    output logic            space,
    sgrp_result_if.source   results
);
    import sgrp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               pop;
    result_t            head;

    assign pop   = results.valid && results.ready;
    assign space = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign head  = entry_reg[rd_ptr_reg];

    assign results.valid        = count_reg != '0;
    assign results.kind         = head.kind;
    assign results.field_number = head.field_number;
    assign results.position     = head.position;
    assign results.value        = head.value;
    assign results.error_code   = head.error_code;
    assign results.end_of_run   = head.end_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.count != 2'd0)
                entry_reg[wr_ptr_reg] <= push.a;
            if (push.count == 2'd2)
                entry_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= push.b;
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push.count) - CNT_W'(pop);
        end
    end

endmodule

>>> design/surface_grid_record_parser_top.sv
`timescale 1ns / 1ps
// top level of the surface grid record parser
//
//  channel   dir  handshake      payload
//  words     in   valid/ready    word, start_of_file, last_word
//  results   out  valid/ready    kind, field_number, position, value, error_code, end_of_run
//  cfg       in   cfg_we         cfg_wdata (expected header identifier)
//
// one word request is taken every cycle while the queue has room; each word is decoded
// in the cycle it is taken and its results, none, one or two, land in a four-entry
// queue. words.ready drops only while the queue holds more than two results, so
// output stalls back up into the input. rst_n clears the parser to the header phase
// and empties the queue; start_of_file clears it for a new file.
module surface_grid_record_parser_top #(
    parameter int MAX_GRID_CELLS = sgrp_pkg::MAX_GRID_CELLS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sgrp_word_if.sink                          words,
    sgrp_result_if.source                      results,
    input  logic                               cfg_we,
    input  logic signed [sgrp_pkg::WORD_W-1:0] cfg_wdata
);
    import sgrp_pkg::*;

    push_t push;
    logic  space;
    logic  accept;

    // accept only with room for the worst case of two results
    assign words.ready = space;
    assign accept      = words.valid && words.ready;

    sgrp_parser #(
        .MAX_GRID_CELLS (MAX_GRID_CELLS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .word          (words.word),
        .start_of_file (words.start_of_file),
        .last_word     (words.last_word),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .push          (push)
    );

    sgrp_result_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .space   (space),
        .results (results)
    );

endmodule

>>> dv/tb_surface_grid_record_parser_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the surface grid record parser top level
module tb_surface_grid_record_parser_top;
    import sgrp_pkg::*;

    localparam longint unsigned GRID_CELL_LIMIT = MAX_GRID_CELLS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 1350;
    localparam int DRAIN_SLACK  = 4;
    localparam int END_SLACK    = 16;

    // parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        PARSE_HEADER,
        PARSE_REC_HEAD,
        PARSE_VALUES,
        PARSE_REC_TAIL,
        PARSE_DONE,
        PARSE_FAILED
    } parse_phase_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic signed [WORD_W-1:0]  cfg_wdata;

    sgrp_word_if   words ();
    sgrp_result_if results ();

    surface_grid_record_parser_top #(
        .MAX_GRID_CELLS(MAX_GRID_CELLS_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .words     (words),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor copy of the parser state and the identifier register
    parse_phase_t      parse_phase;
    int unsigned       hdr_count;
    longint unsigned   grid_rows;
    longint unsigned   grid_cols;
    logic [WORD_W-1:0] rec_len;
    int unsigned       vals_left;
    int unsigned       cells_seen;
    int unsigned       col_ctr;
    int unsigned       row_ctr;
    int unsigned       col_base;
    logic [WORD_W-1:0] id_setting;

    // results predicted but not yet seen on the result channel
    result_t           pending_results[$];
    // logical (big-endian) words of the file under construction
    logic [WORD_W-1:0] file_buf[$];

    int unsigned words_accepted = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    // knobs shared by the sender, the receiver and the tests
    bit tx_gap_en      = 1'b1;
    bit rx_stall_en    = 1'b1;
    int rx_stall_left  = 0;
    int rx_hold_cycles = 0;

    // the file stores bytes big-endian, the bus carries the first byte in bits 7:0
    function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic longint unsigned clamp_size(input logic [WORD_W-1:0] w);
        return (64'(w) > GRID_CELL_LIMIT) ? GRID_CELL_LIMIT + 1 : 64'(w);
    endfunction

    function automatic longint unsigned grid_cells();
        return grid_rows * grid_cols;
    endfunction

    function automatic void clear_parser();
        parse_phase = PARSE_HEADER;
        hdr_count   = 0;
        grid_rows   = 0;
        grid_cols   = 0;
        rec_len     = '0;
        vals_left   = 0;
        cells_seen  = 0;
        col_ctr     = 0;
        row_ctr     = 0;
        col_base    = 0;
    endfunction

    function automatic void expect_result(input kind_t k, input logic [FIELD_W-1:0] field,
                                          input logic [POS_W-1:0] pos,
                                          input logic [WORD_W-1:0] val, input err_t code);
        result_t r;
        r.kind         = k;
        r.field_number = field;
        r.position     = pos;
        r.value        = val;
        r.error_code   = code;
        r.end_of_run   = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void raise_error(input err_t code);
        expect_result(KIND_ERROR, '0, '0, '0, code);
        parse_phase = PARSE_FAILED;
    endfunction

    // works out the results of one accepted word request
    function automatic void parse_word(input logic [WORD_W-1:0] bus_word, input bit sof,
                                       input bit last);
        logic [WORD_W-1:0] w;
        int unsigned       prior_count;
        int unsigned       q;
        result_t           tail;
        w           = byte_swap(bus_word);
        prior_count = pending_results.size();
        words_accepted++;
        if (sof)
            clear_parser();

        case (parse_phase)
            PARSE_HEADER:
            begin
                // record one: length, id, seven fields, trailer
                if (hdr_count == 0 && w != REC1_LEN)
                    raise_error(ERR_CHUNK);
                else if (hdr_count == 1 && w != id_setting)
                    raise_error(ERR_ID);
                else if (hdr_count >= 2 && hdr_count <= 8)
                begin
                    if (hdr_count == 2)
                        grid_rows = clamp_size(w);
                    expect_result(KIND_FIELD, FIELD_W'(hdr_count - 2), '0, w, ERR_NONE);
                end
                else if (hdr_count == 9 && w != REC1_LEN)
                    raise_error(ERR_TRAILER);
                // record two: nx and the rotation fields
                else if (hdr_count == 10 && w != REC2_LEN)
                    raise_error(ERR_CHUNK);
                else if (hdr_count >= 11 && hdr_count <= 14)
                begin
                    if (hdr_count == 11)
                        grid_cols = clamp_size(w);
                    expect_result(KIND_FIELD, FIELD_W'(hdr_count - 4), '0, w, ERR_NONE);
                end
                else if (hdr_count == 15 && w != REC2_LEN)
                    raise_error(ERR_TRAILER);
                // record three: contents skipped, trailer closes the header
                else if (hdr_count == 16 && w != REC3_LEN)
                    raise_error(ERR_CHUNK);
                else if (hdr_count >= 24)
                begin
                    if (w != REC3_LEN)
                        raise_error(ERR_TRAILER);
                    else if (grid_rows > GRID_CELL_LIMIT || grid_cols > GRID_CELL_LIMIT ||
                             grid_cells() > GRID_CELL_LIMIT)
                        raise_error(ERR_GRID_SIZE);
                    else if (grid_cells() == 0)
                    begin
                        expect_result(KIND_DONE, '0, '0, '0, ERR_NONE);
                        parse_phase = PARSE_DONE;
                    end
                    else
                        parse_phase = PARSE_REC_HEAD;
                end
                if (parse_phase == PARSE_HEADER)
                    hdr_count = (hdr_count + 1) & 31;
            end
            PARSE_REC_HEAD:
            begin
                q = w >> 2;
                if (w[WORD_W-1])
                    raise_error(ERR_CHUNK);
                else if (64'(cells_seen) + 64'(q) > grid_cells())
                    raise_error(ERR_OVERRUN);
                else
                begin
                    rec_len     = w;
                    vals_left   = q;
                    parse_phase = (q != 0) ? PARSE_VALUES : PARSE_REC_TAIL;
                end
            end
            PARSE_VALUES:
            begin
                // file order is row-major over nx, the output is column-major over ny
                expect_result(KIND_VALUE, '0, POS_W'(row_ctr + col_base), w, ERR_NONE);
                cells_seen++;
                col_ctr++;
                col_base += 32'(grid_rows);
                if (64'(col_ctr) >= grid_cols)
                begin
                    col_ctr  = 0;
                    col_base = 0;
                    row_ctr++;
                end
                vals_left--;
                if (vals_left == 0)
                    parse_phase = PARSE_REC_TAIL;
            end
            PARSE_REC_TAIL:
            begin
                if (w != rec_len)
                    raise_error(ERR_BLOCK);
                else if (64'(cells_seen) >= grid_cells())
                begin
                    expect_result(KIND_DONE, '0, '0, '0, ERR_NONE);
                    parse_phase = PARSE_DONE;
                end
                else
                    parse_phase = PARSE_REC_HEAD;
            end
            default: ;
        endcase

        if (last && parse_phase != PARSE_DONE && parse_phase != PARSE_FAILED)
            raise_error(ERR_TRUNCATED);

        if (pending_results.size() > prior_count)
        begin
            tail = pending_results.pop_back();
            tail.end_of_run = 1'b1;
            pending_results.push_back(tail);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // checks results first, then predicts from the word request taken at the same edge
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d value %0h", results.kind,
                           results.value);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("kind", WORD_W'(want.kind), WORD_W'(results.kind));
                    compare_field("field_number", WORD_W'(want.field_number),
                                  WORD_W'(results.field_number));
                    compare_field("position", WORD_W'(want.position),
                                  WORD_W'(results.position));
                    compare_field("value", want.value, results.value);
                    compare_field("error_code", WORD_W'(want.error_code),
                                  WORD_W'(results.error_code));
                    compare_field("end_of_run", WORD_W'(want.end_of_run),
                                  WORD_W'(results.end_of_run));
                end
            end
            if (words.valid && words.ready)
                parse_word(words.word, words.start_of_file, words.last_word);
        end
    end

    // result receiver: random stall per result, plus a long hold on request of a test
    always @(posedge clk)
    begin
        if (results.valid && results.ready)
            rx_stall_left = rx_stall_en ? $urandom_range(0, 14) : 0;
        if (!rst_n)
            results.ready <= 1'b0;
        else if (rx_hold_cycles > 0)
        begin
            results.ready <= 1'b0;
            rx_hold_cycles--;
        end
        else if (rx_stall_left > 0)
        begin
            results.ready <= 1'b0;
            rx_stall_left--;
        end
        else
            results.ready <= 1'b1;
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one word request; returns at the edge that accepted it, valid still high
    task automatic send_word(input logic [WORD_W-1:0] file_word, input bit sof,
                             input bit last);
        int gap;
        gap = tx_gap_en ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            words.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        words.valid         <= 1'b1;
        words.word          <= byte_swap(file_word);
        words.start_of_file <= sof;
        words.last_word     <= last;
        @(posedge clk);
        while (!words.ready)
            @(posedge clk);
    endtask

    // sends file_buf[from..to-1]; the first word opens the file, last_word on the final one if mark_last
    task automatic send_span(input int from, input int to, input bit mark_last);
        for (int i = from; i < to; i++)
            send_word(file_buf[i], i == 0, mark_last && i == file_buf.size() - 1);
    endtask

    task automatic wait_for_drain();
        words.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // words that cause no result may still be in flight
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic set_header_id(input logic [WORD_W-1:0] id_value);
        wait_for_drain();
        cfg_wdata <= id_value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        id_setting = id_value;
    endtask

    function automatic logic [WORD_W-1:0] grid_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // 25 header words: three framed records around id, ny, nx and the float fields
    function automatic void build_header(input logic [WORD_W-1:0] ny,
                                         input logic [WORD_W-1:0] nx,
                                         input logic [WORD_W-1:0] id_word);
        file_buf.delete();
        file_buf.push_back(REC1_LEN);
        file_buf.push_back(id_word);
        file_buf.push_back(ny);
        repeat (6) file_buf.push_back($urandom);
        file_buf.push_back(REC1_LEN);
        file_buf.push_back(REC2_LEN);
        file_buf.push_back(nx);
        repeat (3) file_buf.push_back($urandom);
        file_buf.push_back(REC2_LEN);
        file_buf.push_back(REC3_LEN);
        repeat (7) file_buf.push_back($urandom);
        file_buf.push_back(REC3_LEN);
    endfunction

    // one data record of q values; spare bytes make the length not a multiple of four
    function automatic void add_record(input int unsigned q, input int unsigned spare);
        logic [WORD_W-1:0] len;
        len = 4 * q + spare;
        file_buf.push_back(len);
        repeat (q) file_buf.push_back(grid_value());
        file_buf.push_back(len);
    endfunction

    function automatic void add_records(input int unsigned cells);
        int unsigned left;
        int unsigned q;
        left = cells;
        while (left > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                q = 0;
            else
                q = $urandom_range(1, (left < 6) ? left : 6);
            add_record(q, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
            left -= q;
        end
    endfunction

    // bad lead length, wrong id, ignored words after an error, truncation
    task automatic test_header_checks();
        send_word(32'd33, 1'b1, 1'b0);
        send_word(REC1_LEN, 1'b0, 1'b0);
        send_word(REC1_LEN, 1'b1, 1'b0);
        send_word(~id_setting, 1'b0, 1'b0);
        send_word(REC1_LEN, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b1, 1'b1);
    endtask

    // negative ny, nx above the cell limit, product above the limit
    task automatic test_grid_size_limits();
        build_header(32'hFFFF_FFFF, 32'd1, id_setting);
        send_span(0, file_buf.size(), 1'b0);
        build_header(32'd1, 32'(GRID_CELL_LIMIT + 1), id_setting);
        send_span(0, file_buf.size(), 1'b0);
        build_header(32'd4096, 32'd4097, id_setting);
        send_span(0, file_buf.size(), 1'b0);
    endtask

    // nx zero completes at the header; words after completion are ignored
    task automatic test_empty_grid();
        build_header(32'd3, 32'd0, id_setting);
        send_span(0, file_buf.size(), 1'b1);
        send_word($urandom, 1'b0, 1'b0);
        send_word($urandom, 1'b0, 1'b1);
    endtask

    // zero-length record and lengths that are not a multiple of four
    task automatic test_record_framing();
        build_header(32'd2, 32'd3, id_setting);
        add_record(0, 0);
        add_record(2, 1);
        add_record(4, 3);
        send_span(0, file_buf.size(), 1'b1);
        send_word($urandom, 1'b0, 1'b0);
    endtask

    // negative record length, record past the grid end, trailer mismatch
    task automatic test_bad_records();
        build_header(32'd2, 32'd2, id_setting);
        file_buf.push_back(32'h8000_0004);
        send_span(0, file_buf.size(), 1'b0);
        build_header(32'd2, 32'd2, id_setting);
        file_buf.push_back(32'd20);
        send_span(0, file_buf.size(), 1'b0);
        build_header(32'd2, 32'd2, id_setting);
        file_buf.push_back(32'd8);
        file_buf.push_back(32'h0000_0000);
        file_buf.push_back(32'hFFFF_FFFF);
        file_buf.push_back(32'd12);
        send_span(0, file_buf.size(), 1'b0);
    endtask

    // largest grid the limit allows; the last value of a record
    // and a truncation error come from the same word
    task automatic test_largest_grid();
        build_header(32'd4096, 32'd4096, id_setting);
        file_buf.push_back(32'd64);
        repeat (15) file_buf.push_back(grid_value());
        send_span(0, file_buf.size(), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
    endtask

    // identifier register at its extremes, each followed by a one-cell file
    task automatic test_header_id_settings();
        logic [WORD_W-1:0] ids[5];
        ids = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                HEADER_ID_RESET};
        foreach (ids[i])
        begin
            set_header_id(ids[i]);
            build_header(32'd1, 32'd1, id_setting);
            add_records(1);
            send_span(0, file_buf.size(), 1'b1);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the queue fills up
    task automatic test_backpressure();
        wait_for_drain();
        tx_gap_en      = 1'b0;
        rx_hold_cycles = 120;
        build_header(32'd4, 32'd5, id_setting);
        add_records(20);
        send_span(0, file_buf.size(), 1'b1);
        wait_for_drain();
        tx_gap_en = 1'b1;
    endtask

    // sender stops mid-file until every predicted result has arrived
    task automatic test_mid_file_pause();
        build_header(32'd3, 32'd3, id_setting);
        add_records(9);
        send_span(0, 30, 1'b0);
        wait_for_drain();
        send_span(30, file_buf.size(), 1'b1);
    endtask

    // mostly well-formed files with random content, some broken, some loose noise
    task automatic test_random_files();
        int unsigned       target;
        int unsigned       style;
        int unsigned       k;
        int unsigned       cells;
        logic [WORD_W-1:0] ny;
        logic [WORD_W-1:0] nx;
        logic [WORD_W-1:0] id_word;
        bit                mark_last;
        target = words_accepted + RANDOM_WORDS;
        while (words_accepted < target)
        begin
            // stretches with and without idling on either side
            tx_gap_en   = ($urandom_range(0, 2) != 0);
            rx_stall_en = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       set_header_id($urandom);
                    1:       set_header_id(32'h8000_0000);
                    2:       set_header_id(32'h7FFF_FFFF);
                    default: set_header_id(HEADER_ID_RESET);
                endcase
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(3, 12))
                    send_word($urandom, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            end
            else
            begin
                style = $urandom_range(0, 24);
                case (style)
                    0:
                    begin
                        ny = $urandom;
                        nx = $urandom_range(0, 3);
                    end
                    1:
                    begin
                        ny = 32'd1;
                        nx = 32'h8000_0000 | $urandom;
                    end
                    2:
                    begin
                        ny = 32'd4096;
                        nx = 32'd4097;
                    end
                    default:
                    begin
                        ny = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                        nx = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                    end
                endcase
                cells   = (ny <= 6 && nx <= 6) ? ny * nx : 0;
                id_word = ($urandom_range(0, 19) == 0) ? $urandom : id_setting;
                build_header(ny, nx, id_word);
                add_records(cells);
                mark_last = $urandom_range(0, 1);
                if ($urandom_range(0, 3) == 0)
                begin
                    // damage one word: overwrite, flip a bit, drop it or cut the file
                    k = $urandom_range(0, file_buf.size() - 1);
                    case ($urandom_range(0, 3))
                        0: file_buf[k] = $urandom;
                        1: file_buf[k] = file_buf[k] ^ (32'd1 << $urandom_range(0, 31));
                        2: file_buf.delete(k);
                        default:
                        begin
                            while (file_buf.size() > k + 1)
                                void'(file_buf.pop_back());
                            mark_last = 1'b1;
                        end
                    endcase
                end
                send_span(0, file_buf.size(), mark_last);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word($urandom, 1'b0, $urandom_range(0, 1));
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        words.valid         = 1'b0;
        words.word          = '0;
        words.start_of_file = 1'b0;
        words.last_word     = 1'b0;
        id_setting          = HEADER_ID_RESET;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_grid_size_limits();
        test_empty_grid();
        test_record_framing();
        test_bad_records();
        test_largest_grid();
        test_header_id_settings();
        test_backpressure();
        test_mid_file_pause();
        test_random_files();

        wait_for_drain();
        repeat (END_SLACK) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
